>>> rtl/dcq_pkg.sv
package dcq_pkg;

	// Field widths of one item and one result
	localparam int OP_W    = 3;
	localparam int CODE_W  = 4;
	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 11;
	localparam int COUNT_W = 7;

	// Default store depths
	localparam int DEF_COMMAND_DEPTH = 64;
	localparam int DEF_BYTE_DEPTH    = 1024;

	// Code 15 names no command; pushes of it are dropped
	localparam logic [CODE_W-1:0] CODE_NONE = 4'd15;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_CMD   = 3'd0,
		OP_PUSH_BYTE  = 3'd1,
		OP_DRAIN_BEG  = 3'd2,
		OP_POP_CMD    = 3'd3,
		OP_POP_BYTE   = 3'd4,
		OP_DRAIN_END  = 3'd5
	} op_t;

endpackage

>>> rtl/dcq_ifs.sv
interface dcq_req_if import dcq_pkg::*; ();
	logic              valid;
	logic              ready;
	op_t               op;
	logic [CODE_W-1:0] command_code;
	logic [BYTE_W-1:0] data_byte;
	logic              block_start;
	logic [LEN_W-1:0]  block_len;

	modport source (output valid, op, command_code, data_byte, block_start, block_len,
		input ready);
	modport sink (input valid, op, command_code, data_byte, block_start, block_len,
		output ready);
endinterface

interface dcq_rsp_if import dcq_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CODE_W-1:0]  popped_command;
	logic [BYTE_W-1:0]  popped_byte;
	logic               pop_valid;
	logic               last_command;
	logic               overflowed;
	logic [COUNT_W-1:0] queued_count;

	modport source (output valid, popped_command, popped_byte, pop_valid, last_command,
		overflowed, queued_count, input ready);
	modport sink (input valid, popped_command, popped_byte, pop_valid, last_command,
		overflowed, queued_count, output ready);
endinterface

>>> rtl/dcq_ram.sv
module dcq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/deferred_command_queue.sv
// Deferred command queue. Commands (4-bit codes) and their argument bytes are
// kept in two single-port-write RAMs with a registered read. Every accepted
// item yields exactly one result through stage 1 and the output register. Its
// pointer and latch updates and any RAM write or read are issued at the
// accepting edge, the RAM read data lands in stage 1, and stage 1 then loads
// the output register. A new item is taken every cycle while results are
// drained, so the sustained rate is one item per cycle; a stall on the result
// side backs up through stage 1 to the input. The stores need no clearing
// after reset: pops only read entries below the fill counts. Overflow latches
// on a push to a full command store or when a block's first byte finds too
// little byte room (the newest command is then withdrawn); while latched, all
// pushes are ignored until a drain start. A drain end empties both stores but
// leaves the latch alone. queued_count shows the low 7 bits of the count.
module deferred_command_queue import dcq_pkg::*; #(
	parameter int COMMAND_DEPTH = DEF_COMMAND_DEPTH,
	parameter int BYTE_DEPTH    = DEF_BYTE_DEPTH
) (
	input logic    clk,
	input logic    arst_n,
	dcq_req_if.sink   req,
	dcq_rsp_if.source rsp
);

	localparam int CW   = $clog2(COMMAND_DEPTH + 1); // command count
	localparam int CA   = $clog2(COMMAND_DEPTH);     // command address
	localparam int BW   = $clog2(BYTE_DEPTH + 1);    // byte fill
	localparam int BA   = $clog2(BYTE_DEPTH);        // byte address
	localparam int CMPW = (BW > LEN_W) ? BW : LEN_W; // room check width

	// Architectural state
	logic [CW-1:0] cmd_total_q, cmd_total_d;
	logic [CW-1:0] cmd_rd_q, cmd_rd_d;
	logic [BW-1:0] byte_fill_q, byte_fill_d;
	logic [BW-1:0] byte_rd_q, byte_rd_d;
	logic          ovf_q, ovf_d;

	// Stage 1: waiting on RAM read data
	logic               s1_valid_q;
	logic               cmd_hit_s1, byte_hit_s1, last_s1, ovf_s1;
	logic [COUNT_W-1:0] count_s1;

	// Output register
	logic               rsp_valid_q;
	logic [CODE_W-1:0]  cmd_out_q;
	logic [BYTE_W-1:0]  byte_out_q;
	logic               pop_valid_q, last_q, ovf_out_q;
	logic [COUNT_W-1:0] count_out_q;

	// RAM ports
	logic              cmd_we, cmd_re, byte_we, byte_re;
	logic [CODE_W-1:0] cmd_rdata;
	logic [BYTE_W-1:0] byte_rdata;

	logic acc, adv;
	logic cmd_hit, byte_hit, last_hit;
	logic [BW-1:0] byte_room;

	assign adv       = s1_valid_q && (!rsp_valid_q || rsp.ready);
	assign req.ready = !s1_valid_q || adv;
	assign acc       = req.valid && req.ready;
	assign byte_room = BW'(BYTE_DEPTH) - byte_fill_q;

	always_comb begin
		cmd_total_d = cmd_total_q;
		cmd_rd_d    = cmd_rd_q;
		byte_fill_d = byte_fill_q;
		byte_rd_d   = byte_rd_q;
		ovf_d       = ovf_q;
		cmd_we      = 1'b0;
		byte_we     = 1'b0;
		cmd_re      = 1'b0;
		byte_re     = 1'b0;
		cmd_hit     = 1'b0;
		byte_hit    = 1'b0;
		last_hit    = 1'b0;
		if (acc) begin
			case (req.op)
				OP_PUSH_CMD: begin
					if (!ovf_q && req.command_code != CODE_NONE) begin
						if (cmd_total_q < CW'(COMMAND_DEPTH)) begin
							cmd_we      = 1'b1;
							cmd_total_d = cmd_total_q + CW'(1);
						end else begin
							ovf_d = 1'b1;
						end
					end
				end
				OP_PUSH_BYTE: begin
					if (!ovf_q) begin
						if (req.block_start &&
							CMPW'(byte_room) < CMPW'(req.block_len)) begin
							// block cannot fit: withdraw its command
							if (cmd_total_q != '0) begin
								cmd_total_d = cmd_total_q - CW'(1);
							end
							ovf_d = 1'b1;
						end else if (byte_fill_q < BW'(BYTE_DEPTH)) begin
							byte_we     = 1'b1;
							byte_fill_d = byte_fill_q + BW'(1);
						end
					end
				end
				OP_DRAIN_BEG: begin
					ovf_d     = 1'b0;
					cmd_rd_d  = '0;
					byte_rd_d = '0;
				end
				OP_POP_CMD: begin
					if (cmd_rd_q < cmd_total_q) begin
						cmd_re   = 1'b1;
						cmd_hit  = 1'b1;
						last_hit = (cmd_rd_q + CW'(1)) == cmd_total_q;
						cmd_rd_d = cmd_rd_q + CW'(1);
					end
				end
				OP_POP_BYTE: begin
					if (byte_rd_q < byte_fill_q) begin
						byte_re   = 1'b1;
						byte_hit  = 1'b1;
						byte_rd_d = byte_rd_q + BW'(1);
					end
				end
				OP_DRAIN_END: begin
					cmd_total_d = '0;
					byte_fill_d = '0;
					cmd_rd_d    = '0;
					byte_rd_d   = '0;
				end
				default: begin
				end
			endcase
		end
	end

	dcq_ram #(.WIDTH(CODE_W), .DEPTH(COMMAND_DEPTH)) u_cmd_ram (
		.clk   (clk),
		.we    (cmd_we),
		.waddr (cmd_total_q[CA-1:0]),
		.wdata (req.command_code),
		.re    (cmd_re),
		.raddr (cmd_rd_q[CA-1:0]),
		.rdata (cmd_rdata)
	);

	dcq_ram #(.WIDTH(BYTE_W), .DEPTH(BYTE_DEPTH)) u_byte_ram (
		.clk   (clk),
		.we    (byte_we),
		.waddr (byte_fill_q[BA-1:0]),
		.wdata (req.data_byte),
		.re    (byte_re),
		.raddr (byte_rd_q[BA-1:0]),
		.rdata (byte_rdata)
	);

	// State, stage 1 and output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_total_q <= '0;
			cmd_rd_q    <= '0;
			byte_fill_q <= '0;
			byte_rd_q   <= '0;
			ovf_q       <= 1'b0;
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			cmd_total_q <= cmd_total_d;
			cmd_rd_q    <= cmd_rd_d;
			byte_fill_q <= byte_fill_d;
			byte_rd_q   <= byte_rd_d;
			ovf_q       <= ovf_d;
			if (acc) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_hit_s1  <= cmd_hit;
			byte_hit_s1 <= byte_hit;
			last_s1     <= last_hit;
			ovf_s1      <= ovf_d;
			count_s1    <= COUNT_W'(cmd_total_d);
		end
		if (adv) begin
			cmd_out_q   <= cmd_hit_s1 ? cmd_rdata : '0;
			byte_out_q  <= byte_hit_s1 ? byte_rdata : '0;
			pop_valid_q <= cmd_hit_s1 || byte_hit_s1;
			last_q      <= last_s1;
			ovf_out_q   <= ovf_s1;
			count_out_q <= count_s1;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.popped_command = cmd_out_q;
	assign rsp.popped_byte    = byte_out_q;
	assign rsp.pop_valid      = pop_valid_q;
	assign rsp.last_command   = last_q;
	assign rsp.overflowed     = ovf_out_q;
	assign rsp.queued_count   = count_out_q;

	a_cmd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_total_q <= CW'(COMMAND_DEPTH) && cmd_rd_q <= CW'(COMMAND_DEPTH))
		else $error("command pointers out of range");

	a_byte_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_fill_q <= BW'(BYTE_DEPTH) && byte_rd_q <= BW'(BYTE_DEPTH))
		else $error("byte pointers out of range");

	a_no_s1_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && s1_valid_q) |-> adv)
		else $error("stage 1 overwritten before it moved on");

	a_latch_blocks_push: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && ovf_q && (req.op == OP_PUSH_CMD || req.op == OP_PUSH_BYTE))
		|=> ($stable(cmd_total_q) && $stable(byte_fill_q) && ovf_q))
		else $error("push changed state while overflow latched");

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import dcq_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int CMD_SLOTS     = DEF_COMMAND_DEPTH;
	localparam int ARG_SLOTS     = DEF_BYTE_DEPTH;
	localparam int WAIT_MAX      = 12;
	localparam int RANDOM_ITEMS  = 1100;
	// the one long episode that walks the byte store up to full starts here
	localparam int FILL_AT       = 40;
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int REPORT_MAX    = 60;

	// op encodings the package leaves unnamed; the block must treat them as no-ops
	localparam logic [OP_W-1:0]  OP_SPARE_A = 3'd6;
	localparam logic [OP_W-1:0]  OP_SPARE_B = 3'd7;
	localparam logic [LEN_W-1:0] LEN_MAX    = '1;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [CODE_W-1:0] code;
		logic [BYTE_W-1:0] data;
		logic              start;
		logic [LEN_W-1:0]  len;
	} queue_item_t;

	typedef struct packed {
		logic [CODE_W-1:0]  command;
		logic [BYTE_W-1:0]  arg_byte;
		logic               hit;
		logic               last;
		logic               ovf;
		logic [COUNT_W-1:0] count;
	} queue_result_t;

	// one directed row: the item, and a hand-typed result where one is given
	typedef struct packed {
		queue_item_t   item;
		logic          typed;
		queue_result_t want;
	} plan_row_t;

	// Directed opening. Rows with typed=1 are checked against the literal result,
	// the rest against the predictor. Walks: pops on an empty queue, the unused
	// code, zero length, a block that does not fit (withdraws a command), pushes
	// while latched, unused ops, drain start, pops past the end, a push during a
	// drain, an exact-fit block, a withdraw with no command queued, and a drain
	// end that must leave the latch set.
	localparam plan_row_t DIRECTED_PLAN [27] = '{
		'{'{OP_POP_CMD,   4'd0,      8'h00, 1'b0, 11'd1},    1'b1,
			'{4'd0, 8'h00, 1'b0, 1'b0, 1'b0, 7'd0}},
		'{'{OP_POP_BYTE,  4'd0,      8'h00, 1'b0, 11'd1},    1'b1,
			'{4'd0, 8'h00, 1'b0, 1'b0, 1'b0, 7'd0}},
		'{'{OP_PUSH_CMD,  CODE_NONE, 8'h00, 1'b0, 11'd1},    1'b1,
			'{4'd0, 8'h00, 1'b0, 1'b0, 1'b0, 7'd0}},
		'{'{OP_PUSH_CMD,  4'd0,      8'h00, 1'b0, 11'd1},    1'b1,
			'{4'd0, 8'h00, 1'b0, 1'b0, 1'b0, 7'd1}},
		'{'{OP_PUSH_CMD,  4'd14,     8'hff, 1'b1, LEN_MAX},  1'b1,
			'{4'd0, 8'h00, 1'b0, 1'b0, 1'b0, 7'd2}},
		'{'{OP_PUSH_BYTE, 4'd0,      8'hff, 1'b1, 11'd0},    1'b1,
			'{4'd0, 8'h00, 1'b0, 1'b0, 1'b0, 7'd2}},
		'{'{OP_PUSH_BYTE, 4'd15,     8'h00, 1'b1, 11'd3},    1'b1,
			'{4'd0, 8'h00, 1'b0, 1'b0, 1'b0, 7'd2}},
		'{'{OP_PUSH_BYTE, 4'd0,      8'ha5, 1'b0, LEN_MAX},  1'b1,
			'{4'd0, 8'h00, 1'b0, 1'b0, 1'b0, 7'd2}},
		'{'{OP_PUSH_BYTE, 4'd0,      8'h5a, 1'b1, LEN_MAX},  1'b1,
			'{4'd0, 8'h00, 1'b0, 1'b0, 1'b1, 7'd1}},
		'{'{OP_PUSH_CMD,  4'd7,      8'h00, 1'b0, 11'd1},    1'b1,
			'{4'd0, 8'h00, 1'b0, 1'b0, 1'b1, 7'd1}},
		'{'{OP_PUSH_BYTE, 4'd0,      8'h11, 1'b0, 11'd1},    1'b1,
			'{4'd0, 8'h00, 1'b0, 1'b0, 1'b1, 7'd1}},
		'{'{OP_SPARE_A,   4'd0,      8'h00, 1'b0, 11'd1},    1'b1,
			'{4'd0, 8'h00, 1'b0, 1'b0, 1'b1, 7'd1}},
		'{'{OP_SPARE_B,   4'd0,      8'h00, 1'b0, 11'd1},    1'b1,
			'{4'd0, 8'h00, 1'b0, 1'b0, 1'b1, 7'd1}},
		'{'{OP_DRAIN_BEG, 4'd0,      8'h00, 1'b0, 11'd1},    1'b1,
			'{4'd0, 8'h00, 1'b0, 1'b0, 1'b0, 7'd1}},
		'{'{OP_POP_CMD,   4'd0,      8'h00, 1'b0, 11'd1},    1'b1,
			'{4'd0, 8'h00, 1'b1, 1'b1, 1'b0, 7'd1}},
		'{'{OP_POP_CMD,   4'd0,      8'h00, 1'b0, 11'd1},    1'b1,
			'{4'd0, 8'h00, 1'b0, 1'b0, 1'b0, 7'd1}},
		'{'{OP_POP_BYTE,  4'd0,      8'h00, 1'b0, 11'd1},    1'b1,
			'{4'd0, 8'hff, 1'b1, 1'b0, 1'b0, 7'd1}},
		'{'{OP_POP_BYTE,  4'd0,      8'h00, 1'b0, 11'd1},    1'b1,
			'{4'd0, 8'h00, 1'b1, 1'b0, 1'b0, 7'd1}},
		'{'{OP_POP_BYTE,  4'd0,      8'h00, 1'b0, 11'd1},    1'b1,
			'{4'd0, 8'ha5, 1'b1, 1'b0, 1'b0, 7'd1}},
		'{'{OP_POP_BYTE,  4'd0,      8'h00, 1'b0, 11'd1},    1'b1,
			'{4'd0, 8'h00, 1'b0, 1'b0, 1'b0, 7'd1}},
		'{'{OP_PUSH_CMD,  4'd9,      8'h00, 1'b0, 11'd1},    1'b0, '0},
		'{'{OP_POP_CMD,   4'd0,      8'h00, 1'b0, 11'd1},    1'b0, '0},
		'{'{OP_DRAIN_END, 4'd0,      8'h00, 1'b0, 11'd1},    1'b1,
			'{4'd0, 8'h00, 1'b0, 1'b0, 1'b0, 7'd0}},
		'{'{OP_PUSH_BYTE, 4'd0,      8'h3c, 1'b1, 11'd1024}, 1'b0, '0},
		'{'{OP_PUSH_BYTE, 4'd0,      8'hc3, 1'b1, 11'd1024}, 1'b1,
			'{4'd0, 8'h00, 1'b0, 1'b0, 1'b1, 7'd0}},
		'{'{OP_DRAIN_END, 4'd0,      8'h00, 1'b0, 11'd1},    1'b1,
			'{4'd0, 8'h00, 1'b0, 1'b0, 1'b1, 7'd0}},
		'{'{OP_DRAIN_BEG, 4'd0,      8'h00, 1'b0, 11'd1},    1'b1,
			'{4'd0, 8'h00, 1'b0, 1'b0, 1'b0, 7'd0}}
	};

	logic clk = 1'b0;
	logic arst_n;

	dcq_req_if item_bus ();
	dcq_rsp_if result_bus ();

	deferred_command_queue #(
		.COMMAND_DEPTH(CMD_SLOTS),
		.BYTE_DEPTH   (ARG_SLOTS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (item_bus),
		.rsp   (result_bus)
	);

	always #CLK_HALF clk = ~clk;

	// Shadow copy of the queue. Stores start as X: a pop only ever reads below
	// the fill counts, so an X here would itself point at a bad pop.
	logic [CODE_W-1:0] shadow_cmds [CMD_SLOTS];
	logic [BYTE_W-1:0] shadow_args [ARG_SLOTS];
	int   shadow_cmd_count;
	int   shadow_arg_fill;
	int   shadow_cmd_rd;
	int   shadow_arg_rd;
	logic shadow_ovf;

	queue_result_t pending_results [$];
	int mismatches;
	int effective_items;
	int cycle_count;
	int source_calm;
	int sink_calm;

	// Apply one item to the shadow queue and return the result the block owes.
	// ignored flags items that change nothing (latched pushes, the unused code,
	// bytes dropped on a full store, unused ops).
	task automatic predict_queue_result(input queue_item_t it, output queue_result_t r,
		output logic ignored);
		int room;
		r = '0;
		ignored = 1'b0;
		case (it.op)
		OP_PUSH_CMD: begin
			if (shadow_ovf || it.code == CODE_NONE) begin
				ignored = 1'b1;
			end else if (shadow_cmd_count < CMD_SLOTS) begin
				shadow_cmds[shadow_cmd_count] = it.code;
				shadow_cmd_count++;
			end else begin
				shadow_ovf = 1'b1;
			end
		end
		OP_PUSH_BYTE: begin
			room = ARG_SLOTS - shadow_arg_fill;
			if (shadow_ovf) begin
				ignored = 1'b1;
			end else if (it.start && room < int'(it.len)) begin
				// block cannot fit: drop the newest command and latch
				if (shadow_cmd_count > 0)
					shadow_cmd_count--;
				shadow_ovf = 1'b1;
			end else if (shadow_arg_fill < ARG_SLOTS) begin
				shadow_args[shadow_arg_fill] = it.data;
				shadow_arg_fill++;
			end else begin
				ignored = 1'b1;
			end
		end
		OP_DRAIN_BEG: begin
			shadow_ovf    = 1'b0;
			shadow_cmd_rd = 0;
			shadow_arg_rd = 0;
		end
		OP_POP_CMD: begin
			if (shadow_cmd_rd < shadow_cmd_count && shadow_cmd_rd < CMD_SLOTS) begin
				r.command = shadow_cmds[shadow_cmd_rd];
				r.hit     = 1'b1;
				r.last    = (shadow_cmd_rd + 1 == shadow_cmd_count);
				shadow_cmd_rd++;
			end
		end
		OP_POP_BYTE: begin
			if (shadow_arg_rd < shadow_arg_fill && shadow_arg_rd < ARG_SLOTS) begin
				r.arg_byte = shadow_args[shadow_arg_rd];
				r.hit      = 1'b1;
				shadow_arg_rd++;
			end
		end
		OP_DRAIN_END: begin
			shadow_cmd_count = 0;
			shadow_arg_fill  = 0;
			shadow_cmd_rd    = 0;
			shadow_arg_rd    = 0;
		end
		default: begin
			ignored = 1'b1;
		end
		endcase
		r.ovf   = shadow_ovf;
		r.count = shadow_cmd_count[COUNT_W-1:0];
	endtask

	// Per-item wait, 0..WAIT_MAX, with the odd burst of back-to-back items.
	function automatic int draw_wait(ref int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			calm = $urandom_range(8, 40);
		return $urandom_range(0, WAIT_MAX);
	endfunction

	// Present one item, hold it until taken, then queue what the block owes.
	// Valid only drops when a gap follows, so back-to-back items keep it high.
	task automatic send_item(input queue_item_t it, input logic typed,
		input queue_result_t want);
		queue_result_t predicted;
		logic ignored;
		int gap;
		gap = draw_wait(source_calm);
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid        <= 1'b1;
		item_bus.op           <= op_t'(it.op);
		item_bus.command_code <= it.code;
		item_bus.data_byte    <= it.data;
		item_bus.block_start  <= it.start;
		item_bus.block_len    <= it.len;
		do @(posedge clk); while (item_bus.ready !== 1'b1);
		predict_queue_result(it, predicted, ignored);
		pending_results.push_back(typed ? want : predicted);
		if (!ignored)
			effective_items++;
	endtask

	task automatic issue(input int op, input int code, input int data, input int start,
		input int len);
		queue_item_t it;
		it.op    = op[OP_W-1:0];
		it.code  = code[CODE_W-1:0];
		it.data  = data[BYTE_W-1:0];
		it.start = start[0];
		it.len   = len[LEN_W-1:0];
		send_item(it, 1'b0, '0);
	endtask

	// op with junk in every field it should not look at
	task automatic issue_bare(input int op);
		issue(op, $urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 1),
			$urandom_range(0, LEN_MAX));
	endtask

	task automatic send_noise();
		issue_bare($urandom_range(0, OP_SPARE_B));
	endtask

	function automatic int rand_code();
		if ($urandom_range(0, 15) == 0)
			return CODE_NONE;
		return $urandom_range(0, CODE_NONE - 1);
	endfunction

	task automatic push_command();
		issue(OP_PUSH_CMD, rand_code(), $urandom_range(0, 255), $urandom_range(0, 1),
			$urandom_range(0, LEN_MAX));
	endtask

	// Head byte carries len; the body is cut short once the latch trips
	// (everything after is ignored anyway).
	task automatic push_block(input int len, input int nbytes, input bit noisy);
		issue(OP_PUSH_BYTE, $urandom_range(0, 15), $urandom_range(0, 255), 1, len);
		for (int i = 1; i < nbytes && !shadow_ovf; i++) begin
			if (noisy && $urandom_range(0, 19) == 0)
				send_noise();
			issue(OP_PUSH_BYTE, $urandom_range(0, 15), $urandom_range(0, 255), 0,
				$urandom_range(0, LEN_MAX));
		end
	endtask

	// Drain start, then interleaved pops; the odd push lands mid-drain.
	task automatic drain_some(input int cmd_pops, input int byte_pops);
		issue_bare(OP_DRAIN_BEG);
		while (cmd_pops + byte_pops > 0) begin
			if ($urandom_range(0, 15) == 0) begin
				push_command();
			end else if (cmd_pops > 0 && (byte_pops == 0 || $urandom_range(0, 1) == 0)) begin
				issue_bare(OP_POP_CMD);
				cmd_pops--;
			end else begin
				issue_bare(OP_POP_BYTE);
				byte_pops--;
			end
		end
	endtask

	// Short episode: empty the queue (mostly), queue a few commands and small
	// blocks, then drain and pop a little past the end. fill_commands pushes
	// past the command depth to trip the latch on a full command store.
	task automatic run_short_episode(input bit fill_commands);
		int n_cmds;
		int n_blocks;
		int room;
		int len;
		int nbytes;
		if ($urandom_range(0, 7) != 0)
			issue_bare(OP_DRAIN_END);
		n_cmds   = fill_commands ? CMD_SLOTS + $urandom_range(1, 3) : $urandom_range(0, 8);
		n_blocks = $urandom_range(0, 4);
		while (n_cmds + n_blocks > 0) begin
			if ($urandom_range(0, 11) == 0)
				send_noise();
			if (n_cmds > 0 && (n_blocks == 0 || $urandom_range(0, 1) == 0)) begin
				push_command();
				n_cmds--;
			end else begin
				room = ARG_SLOTS - shadow_arg_fill;
				case ($urandom_range(0, 9))
				0: begin
					len    = 0;
					nbytes = 1;
				end
				1: begin
					// too long for the room left: withdraw and latch
					len    = $urandom_range(room + 1, LEN_MAX);
					nbytes = $urandom_range(1, 3);
				end
				default: begin
					len    = $urandom_range(1, 10);
					nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(1, len) : len;
				end
				endcase
				push_block(len, nbytes, 1'b1);
				n_blocks--;
			end
		end
		drain_some(shadow_cmd_count + $urandom_range(0, 2),
			shadow_arg_fill + $urandom_range(0, 2));
	endtask

	// Long episode: blocks until the byte store is full. Near the top each block
	// either fits exactly or misses by one byte; a miss latches, and a short
	// drain clears it before filling resumes. Once full, stray bytes must drop
	// silently and a one-byte block must fail.
	task automatic run_fill_episode();
		int room;
		int len;
		issue_bare(OP_DRAIN_END);
		while (shadow_arg_fill < ARG_SLOTS) begin
			room = ARG_SLOTS - shadow_arg_fill;
			if ($urandom_range(0, 3) == 0)
				push_command();
			if (room > 160)
				len = $urandom_range(20, 150);
			else
				len = ($urandom_range(0, 1) == 0) ? room : room + 1;
			push_block(len, len, 1'b0);
			if (shadow_ovf)
				drain_some($urandom_range(0, 3), $urandom_range(0, 3));
		end
		issue(OP_PUSH_BYTE, 0, $urandom_range(0, 255), 0, $urandom_range(0, LEN_MAX));
		issue(OP_PUSH_BYTE, 0, $urandom_range(0, 255), 1, 0);
		issue(OP_PUSH_BYTE, 0, $urandom_range(0, 255), 1, 1);
		drain_some(shadow_cmd_count + 1, $urandom_range(5, 30));
		issue_bare(OP_DRAIN_END);
	endtask

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// Result side: random back-pressure, each taken result against the oldest
	// outstanding prediction.
	initial begin : result_sink
		queue_result_t want;
		int gap;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = draw_wait(sink_calm);
			if (gap > 0) begin
				result_bus.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_bus.ready <= 1'b1;
			do @(posedge clk); while (result_bus.valid !== 1'b1);
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t unexpected result: expected none, actual cmd %0h byte %0h",
						$time, result_bus.popped_command, result_bus.popped_byte);
			end else begin
				want = pending_results.pop_front();
				check_field("popped_command", 8'(want.command),
					8'(result_bus.popped_command));
				check_field("popped_byte", want.arg_byte, result_bus.popped_byte);
				check_field("pop_valid", 8'(want.hit), 8'(result_bus.pop_valid));
				check_field("last_command", 8'(want.last), 8'(result_bus.last_command));
				check_field("overflowed", 8'(want.ovf), 8'(result_bus.overflowed));
				check_field("queued_count", 8'(want.count), 8'(result_bus.queued_count));
			end
		end
	end

	initial begin : stimulus
		bit fill_done;
		int episode;
		arst_n                = 1'b0;
		item_bus.valid        = 1'b0;
		item_bus.op           = OP_PUSH_CMD;
		item_bus.command_code = '0;
		item_bus.data_byte    = '0;
		item_bus.block_start  = 1'b0;
		item_bus.block_len    = '0;
		result_bus.ready      = 1'b0;
		shadow_cmd_count      = 0;
		shadow_arg_fill       = 0;
		shadow_cmd_rd         = 0;
		shadow_arg_rd         = 0;
		shadow_ovf            = 1'b0;
		effective_items       = 0;
		source_calm           = 0;
		fill_done             = 1'b0;
		episode               = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_PLAN[i])
			send_item(DIRECTED_PLAN[i].item, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);

		// Random episodes; the first fills the command store, the second fills
		// the byte store.
		while (effective_items < RANDOM_ITEMS || !fill_done) begin
			if (!fill_done && effective_items >= FILL_AT) begin
				run_fill_episode();
				fill_done = 1'b1;
			end else begin
				run_short_episode(episode == 0 || $urandom_range(0, 7) == 0);
			end
			episode++;
		end
		item_bus.valid <= 1'b0;

		// let every owed result come back, then a quiet tail for strays
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> files.f
rtl/dcq_pkg.sv
rtl/dcq_ifs.sv
rtl/dcq_ram.sv
rtl/deferred_command_queue.sv
bench/tb.sv
